FILE: hw/rtl/first_fit_block_allocator_unit_defines.svh
// Assertion macros shared by the allocator checker
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Assert that a property holds on every rising clock edge outside reset
`define FFBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert an implication with the antecedent spelt out
`define FFBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ffba_pkg.sv
// Package: constants, codes and payload types of the first-fit allocator
`default_nettype none
package ffba_pkg;
  localparam int unsigned MemWords  = 4096;
  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned AddrW     = 12;
  localparam int unsigned LenW      = 12;
  localparam int unsigned CntW      = 13;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned BcW       = IdxW + 1;
  localparam logic [CntW-1:0] MinTotal = CntW'(8);

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_USAGE = 2'd2,
    KIND_USAGE_ALT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_ROOM    = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [LenW-1:0]  payload_length;
    logic [AddrW-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] start_address;
    logic [CntW-1:0]  used_words;
    logic [CntW-1:0]  total_words;
    logic [1:0]       status;
  } rsp_t;

  // One table entry: block start and payload length
  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [LenW-1:0]  len;
  } entry_t;
endpackage
`default_nettype wire

FILE: hw/rtl/ffba_if.sv
// Valid/ready channel interface carrying one payload
`default_nettype none
interface ffba_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ffba_table_ram.sv
// Block table memory: one write port, one registered read port
`default_nettype none
module ffba_table_ram (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [ffba_pkg::IdxW-1:0] waddr_i,
  input  wire ffba_pkg::entry_t      wdata_i,
  input  wire logic [ffba_pkg::IdxW-1:0] raddr_i,
  output ffba_pkg::entry_t           rdata_o
);
  import ffba_pkg::*;
  entry_t mem_q [MaxBlocks];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/first_fit_block_allocator_unit.sv
// Top level: sequential first-fit block allocator over a sorted block table
// One request at a time. The table lives in a single RAM with one read and
// one write per cycle. Allocate: one read per entry up to the chosen gap,
// then a check plus one step per doubling of the total, then a shift-up of
// the entries above the new one, one entry per cycle after an initial read,
// then the write of the new entry. Free: a scan to the match, a shift-down
// of the rest, then a read of the new last entry and halving steps of the
// total, one per cycle, or a reset of the total to its minimum if the table
// empties. A usage query goes straight to the result. The result waits in
// an output register, so the next request is taken while it waits; a finished
// request holds in its last state until that register is free or handed on.
`default_nettype none
module first_fit_block_allocator_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ffba_if.sink      req_i,
  ffba_if.source    rsp_o
);
  import ffba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_AFIND, S_ACHK, S_ASHIFT, S_AINS,
    S_FFIND, S_FSHIFT, S_FLAST, S_FHALVE, S_DONE
  } state_e;

  state_e            state_q;
  req_t              req_q;
  logic [BcW-1:0]    count_q;
  logic [CntW-1:0]   used_q, total_q;
  logic [BcW-1:0]    idx_q;       // table entry under work
  logic [CntW:0]     prev_end_q;  // end of previous block (start of gap)
  logic [CntW:0]     at_q;        // chosen place
  logic [CntW:0]     last_q;      // start+len of last block after free
  logic [BcW-1:0]    ins_q;       // insertion slot
  logic              found_q;
  logic [AddrW-1:0]  start_q;     // start address of the request under work
  status_e           status_q;    // status of the request under work
  rsp_t              rsp_q;
  logic              rsp_valid_q;

  logic              we;
  logic [IdxW-1:0]   waddr, raddr;
  entry_t            wdata, rdata;

  ffba_table_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [CntW:0] need, rd_end;
  assign need   = (CntW+1)'(req_q.payload_length) + 1'b1;
  assign rd_end = (CntW+1)'(rdata.start) + (CntW+1)'(rdata.len) + 1'b1;

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // RAM port steering
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    raddr = idx_q[IdxW-1:0];
    unique case (state_q)
      // read one entry ahead so rdata holds entry idx_q while scanning
      S_IDLE: raddr = '0;
      S_AFIND, S_FFIND: raddr = IdxW'(idx_q + 1'b1);
      S_ASHIFT: begin
        // rdata holds entry idx_q once found_q is set; move it up one
        we    = found_q;
        waddr = IdxW'(idx_q + 1'b1);
        raddr = found_q ? IdxW'(idx_q - 1'b1) : idx_q[IdxW-1:0];
      end
      S_AINS: begin
        we    = 1'b1;
        waddr = ins_q[IdxW-1:0];
        wdata = '{start: at_q[AddrW-1:0], len: req_q.payload_length};
      end
      S_FSHIFT: begin
        we    = found_q;
        waddr = IdxW'(idx_q - 1'b1);
        raddr = found_q ? IdxW'(idx_q + 1'b1) : idx_q[IdxW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      used_q      <= '0;
      total_q     <= MinTotal;
      rsp_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid && req_i.ready) begin
            req_q <= req_i.data;
            start_q  <= '0;
            status_q <= ST_OK;
            idx_q      <= '0;
            prev_end_q <= '0;
            found_q    <= 1'b0;
            priority case (req_i.data.kind)
              KIND_ALLOC: begin
                if (count_q == BcW'(MaxBlocks)) begin
                  status_q <= ST_TABLE_FULL;
                  state_q  <= S_DONE;
                end else if (count_q == '0) begin
                  at_q    <= '0;
                  ins_q   <= '0;
                  state_q <= S_ACHK;
                end else begin
                  state_q <= S_AFIND;
                end
              end
              KIND_FREE: begin
                if (count_q == '0) begin
                  status_q <= ST_NOT_FOUND;
                  state_q  <= S_DONE;
                end else begin
                  state_q <= S_FFIND;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        // rdata = entry idx_q; test the gap before it
        S_AFIND: begin
          if (prev_end_q + need <= (CntW+1)'(rdata.start)) begin
            at_q    <= prev_end_q;
            ins_q   <= idx_q;
            state_q <= S_ACHK;
          end else if (idx_q + 1'b1 == count_q) begin
            at_q    <= rd_end;
            ins_q   <= count_q;
            state_q <= S_ACHK;
          end else begin
            prev_end_q <= rd_end;
            idx_q      <= idx_q + 1'b1;
          end
        end
        S_ACHK: begin
          if (at_q + need > (CntW+1)'(MemWords)) begin
            status_q <= ST_NO_ROOM;
            state_q  <= S_DONE;
          end else if ((CntW+1)'(total_q) < at_q + need) begin
            total_q <= CntW'({total_q, 1'b0});
          end else if (ins_q == count_q) begin
            state_q <= S_AINS;
          end else begin
            idx_q   <= count_q - 1'b1;
            state_q <= S_ASHIFT; // first read issued below next cycle
            found_q <= 1'b0;
          end
        end
        S_ASHIFT: begin
          // first cycle only issues the read of the top entry
          if (!found_q) begin
            found_q <= 1'b1;
          end else if (idx_q == ins_q) begin
            state_q <= S_AINS;
          end else begin
            idx_q <= idx_q - 1'b1;
          end
        end
        S_AINS: begin
          count_q <= count_q + 1'b1;
          used_q  <= used_q + need[CntW-1:0];
          start_q <= at_q[AddrW-1:0];
          state_q <= S_DONE;
        end
        S_FFIND: begin
          if (rdata.start == req_q.block_address) begin
            used_q <= used_q - (CntW'(rdata.len) + 1'b1);
            if (idx_q + 1'b1 == count_q) begin
              state_q <= S_FLAST;
            end else begin
              idx_q   <= idx_q + 1'b1;
              found_q <= 1'b0;
              state_q <= S_FSHIFT;
            end
          end else if (idx_q + 1'b1 == count_q) begin
            status_q <= ST_NOT_FOUND;
            state_q  <= S_DONE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_FSHIFT: begin
          // first cycle waits for the read of idx_q; write is suppressed by found_q
          if (!found_q) begin
            found_q <= 1'b1;
          end else if (idx_q + 1'b1 == count_q) begin
            state_q <= S_FLAST;
            idx_q   <= idx_q - 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_FLAST: begin
          count_q <= count_q - 1'b1;
          if (count_q == BcW'(1)) begin
            total_q <= MinTotal;
            state_q <= S_DONE;
          end else begin
            idx_q   <= count_q - BcW'(2);
            found_q <= 1'b0;
            state_q <= S_FHALVE;
          end
        end
        S_FHALVE: begin
          if (!found_q) begin
            found_q <= 1'b1; // wait for the read of the last entry
          end else if (found_q && last_q == '1) begin
            last_q <= (CntW+1)'(rdata.start) + (CntW+1)'(rdata.len);
          end else if (({last_q, 2'b00}) <= (CntW+3)'(total_q) && total_q > MinTotal) begin
            total_q <= total_q >> 1;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free or handed on this cycle
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_q.start_address <= start_q;
            rsp_q.used_words    <= used_q;
            rsp_q.total_words   <= total_q;
            rsp_q.status        <= status_q;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_FLAST) last_q <= '1;
      if (state_q == S_DONE && (!rsp_valid_q || rsp_o.ready)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ffba_checker.sv
// Port-level checker for the allocator, bound to the top level
`default_nettype none
`include "first_fit_block_allocator_unit_defines.svh"
module ffba_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire ffba_pkg::rsp_t rsp
);
  import ffba_pkg::*;
  `FFBA_ASSERT_IMP(a_hold, rsp_valid && !rsp_ready, ##1 rsp_valid && $stable(rsp),
                   "result changed while stalled")
  `FFBA_ASSERT(a_total_min, !rsp_valid || rsp.total_words >= MinTotal, "total below eight")
  `FFBA_ASSERT(a_pow2, !rsp_valid || $onehot(rsp.total_words), "total not a power of two")
  `FFBA_ASSERT_IMP(a_fail_zero, rsp_valid && rsp.status != ST_OK, rsp.start_address == '0,
                   "failed request gave an address")
  `FFBA_ASSERT_IMP(a_used_bound, rsp_valid, rsp.used_words <= rsp.total_words,
                   "used words exceed total")
endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
  .clk_i, .rst_ni,
  .req_valid(req_i.valid), .req_ready(req_i.ready),
  .rsp_valid(rsp_o.valid), .rsp_ready(rsp_o.ready), .rsp(rsp_o.data)
);
`default_nettype wire

FILE: dv/tb_first_fit_block_allocator_unit.sv
// Self-checking testbench for the first-fit block allocator
module tb_first_fit_block_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;

  ffba_if #(.T(req_t)) req_ch ();
  ffba_if #(.T(rsp_t)) rsp_ch ();

  first_fit_block_allocator_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Allocator state as predicted; only entries below held_blocks are read
  logic [AddrW-1:0] pred_start [MaxBlocks];
  logic [LenW-1:0]  pred_len   [MaxBlocks];
  int unsigned      held_blocks;
  int unsigned      words_in_use;
  int unsigned      store_total;

  req_t pending_reqs[$];
  rsp_t awaited_rsps[$];
  int   error_count;
  bit   calm_phase;
  bit   hold_sender;
  int   send_gap;
  int   recv_gap;
  longint cycle_count;

  // Work out the response to one request and advance the predicted state
  function automatic rsp_t allocator_response(req_t r);
    rsp_t        o;
    int unsigned need, at, i, last;
    bit          found;
    o = '0;
    o.status = ST_OK;
    if (kind_e'(r.kind) == KIND_ALLOC) begin
      need = r.payload_length + 1;
      if (held_blocks >= MaxBlocks) begin
        o.status = ST_TABLE_FULL;
      end else begin
        // first fit: front gap, inner gaps, then after the last block
        found = 1'b0;
        at = 0;
        if (held_blocks == 0 || need <= pred_start[0]) begin
          found = 1'b1;
        end
        for (i = 0; !found && i + 1 < held_blocks; i++) begin
          at = pred_start[i] + pred_len[i] + 1;
          if (at + need <= pred_start[i+1]) found = 1'b1;
        end
        if (!found) at = pred_start[held_blocks-1] + pred_len[held_blocks-1] + 1;
        if (at + need > MemWords) begin
          o.status = ST_NO_ROOM;
        end else begin
          while (store_total < at + need) store_total *= 2;
          i = held_blocks;
          while (i > 0 && pred_start[i-1] > at) begin
            pred_start[i] = pred_start[i-1];
            pred_len[i]   = pred_len[i-1];
            i--;
          end
          pred_start[i] = AddrW'(at);
          pred_len[i]   = r.payload_length;
          held_blocks++;
          words_in_use += need;
          o.start_address = AddrW'(at);
        end
      end
    end else if (kind_e'(r.kind) == KIND_FREE) begin
      for (i = 0; i < held_blocks; i++) if (pred_start[i] == r.block_address) break;
      if (i >= held_blocks) begin
        o.status = ST_NOT_FOUND;
      end else begin
        words_in_use -= pred_len[i] + 1;
        for (; i + 1 < held_blocks; i++) begin
          pred_start[i] = pred_start[i+1];
          pred_len[i]   = pred_len[i+1];
        end
        held_blocks--;
        if (held_blocks == 0) begin
          store_total = MinTotal;
        end else begin
          last = pred_start[held_blocks-1] + pred_len[held_blocks-1];
          while (4 * last <= store_total && store_total > MinTotal) store_total /= 2;
        end
      end
    end
    o.used_words  = CntW'(words_in_use);
    o.total_words = CntW'(store_total);
    return o;
  endfunction

  function automatic req_t make_req(kind_e k, int unsigned len, int unsigned addr);
    req_t r;
    r.kind           = k;
    r.payload_length = LenW'(len);
    r.block_address  = AddrW'(addr);
    return r;
  endfunction

  // Driver: present queued requests, with random gaps unless in the calm phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      send_gap     <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        awaited_rsps.push_back(allocator_response(req_ch.data));
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the current transfer
      end else if (send_gap > 0) begin
        send_gap     <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        send_gap     <= $urandom_range(1, 15);
        req_ch.valid <= 1'b0;
      end else if (hold_sender || pending_reqs.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else begin
        req_ch.valid <= 1'b1;
        req_ch.data  <= pending_reqs.pop_front();
      end
    end
  end

  // Monitor: compare every response transfer with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      recv_gap     <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_rsps.size() == 0) begin
          $error("unexpected response transfer");
          error_count++;
        end else begin
          exp_rsp = awaited_rsps.pop_front();
          if (rsp_ch.data.start_address !== exp_rsp.start_address) begin
            $error("start_address: expected %0d, got %0d",
                   exp_rsp.start_address, rsp_ch.data.start_address);
            error_count++;
          end
          if (rsp_ch.data.used_words !== exp_rsp.used_words) begin
            $error("used_words: expected %0d, got %0d",
                   exp_rsp.used_words, rsp_ch.data.used_words);
            error_count++;
          end
          if (rsp_ch.data.total_words !== exp_rsp.total_words) begin
            $error("total_words: expected %0d, got %0d",
                   exp_rsp.total_words, rsp_ch.data.total_words);
            error_count++;
          end
          if (rsp_ch.data.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, rsp_ch.data.status);
            error_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap     <= recv_gap - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        recv_gap     <= $urandom_range(1, 15);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Shadow model of held starts, used only to pick valid free addresses
  int unsigned held_shadow[$];

  function automatic bit shadow_ok();
    return held_shadow.size() > 0;
  endfunction

  // Follow allocations through a scratch copy of the first-fit placement
  logic [AddrW-1:0] sh_start [MaxBlocks];
  logic [LenW-1:0]  sh_len   [MaxBlocks];
  int unsigned      sh_count;

  function automatic void track_shadow(req_t r);
    int unsigned need, at, i;
    bit          found;
    if (kind_e'(r.kind) == KIND_ALLOC && sh_count < MaxBlocks) begin
      need = r.payload_length + 1;
      found = 1'b0;
      at = 0;
      if (sh_count == 0 || need <= sh_start[0]) found = 1'b1;
      for (i = 0; !found && i + 1 < sh_count; i++) begin
        at = sh_start[i] + sh_len[i] + 1;
        if (at + need <= sh_start[i+1]) found = 1'b1;
      end
      if (!found) at = sh_start[sh_count-1] + sh_len[sh_count-1] + 1;
      if (at + need <= MemWords) begin
        i = sh_count;
        while (i > 0 && sh_start[i-1] > at) begin
          sh_start[i] = sh_start[i-1];
          sh_len[i]   = sh_len[i-1];
          i--;
        end
        sh_start[i] = AddrW'(at);
        sh_len[i]   = r.payload_length;
        sh_count++;
        held_shadow.push_back(at);
      end
    end else if (kind_e'(r.kind) == KIND_FREE) begin
      for (i = 0; i < sh_count; i++) if (sh_start[i] == r.block_address) break;
      if (i < sh_count) begin
        for (; i + 1 < sh_count; i++) begin
          sh_start[i] = sh_start[i+1];
          sh_len[i]   = sh_len[i+1];
        end
        sh_count--;
        foreach (held_shadow[j]) if (held_shadow[j] == r.block_address) begin
          held_shadow.delete(j);
          break;
        end
      end
    end
  endfunction

  // Random sequence: mostly allocations and frees of held blocks, some noise.
  // A shadow list of held starts is kept in step with the prediction.
  task automatic queue_random(int unsigned count, int unsigned max_len);
    int unsigned n, sel, len, pos;
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, max_len);
        pending_reqs.push_back(make_req(KIND_ALLOC, len, $urandom_range(0, 4095)));
      end else if (sel < 85 && shadow_ok()) begin
        pos = $urandom_range(0, held_shadow.size() - 1);
        pending_reqs.push_back(make_req(KIND_FREE, $urandom_range(0, 4095),
                                        held_shadow[pos]));
        held_shadow.delete(pos);
      end else if (sel < 93) begin
        pending_reqs.push_back(make_req(KIND_FREE, $urandom_range(0, 4095),
                                        $urandom_range(0, 4095)));
      end else begin
        pending_reqs.push_back(make_req(kind_e'($urandom_range(2, 3)),
                                        $urandom_range(0, 4095), $urandom_range(0, 4095)));
      end
      track_shadow(pending_reqs[$]);
    end
  endtask

  task automatic push_directed(kind_e k, int unsigned len, int unsigned addr);
    pending_reqs.push_back(make_req(k, len, addr));
    track_shadow(pending_reqs[$]);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || req_ch.valid || awaited_rsps.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int unsigned n;
    rst_ni       = 1'b0;
    error_count  = 0;
    calm_phase   = 1'b0;
    hold_sender  = 1'b0;
    cycle_count  = 0;
    held_blocks  = 0;
    words_in_use = 0;
    store_total  = MinTotal;
    sh_count     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: free on empty table, query kinds, extremes and the front gap
    push_directed(KIND_FREE, 0, 0);
    push_directed(KIND_USAGE, 4095, 4095);
    push_directed(KIND_USAGE_ALT, 0, 0);
    push_directed(KIND_ALLOC, 4095, 0);      // fills the store exactly
    push_directed(KIND_ALLOC, 4094, 4095);   // no room left
    push_directed(KIND_ALLOC, 0, 0);         // no room left at all
    push_directed(KIND_FREE, 0, 1);          // address not found
    push_directed(KIND_FREE, 0, 0);          // empty again: total back to minimum
    push_directed(KIND_ALLOC, 2, 0);         // 0..2
    push_directed(KIND_ALLOC, 3, 0);         // 3..6
    push_directed(KIND_ALLOC, 100, 0);       // 7..107
    push_directed(KIND_FREE, 0, 0);          // open a front gap of three words
    push_directed(KIND_ALLOC, 2, 0);         // size equals first start: front gap
    push_directed(KIND_FREE, 0, 3);          // inner gap
    push_directed(KIND_ALLOC, 0, 0);         // lands in the inner gap
    push_directed(KIND_FREE, 0, 7);          // total shrinks
    push_directed(KIND_FREE, 0, 3);
    push_directed(KIND_FREE, 0, 0);
    drain();

    // Table full: fill all entries with one-word blocks, then ask for more
    for (n = 0; n < MaxBlocks + 2; n++) push_directed(KIND_ALLOC, 0, 0);
    push_directed(KIND_FREE, 0, 10);
    push_directed(KIND_ALLOC, 0, 0);
    push_directed(KIND_ALLOC, 0, 0);
    drain();
    for (n = 0; n < MaxBlocks; n++) push_directed(KIND_FREE, 0, n);

    // Random: small blocks mostly, so the table fills and gaps form
    queue_random(300, 40);
    repeat (400) @(posedge clk_i);
    hold_sender = 1'b1;   // pause the sender until every response is in
    while (req_ch.valid || awaited_rsps.size() > 0) @(posedge clk_i);
    hold_sender = 1'b0;
    drain();
    queue_random(200, 200);
    drain();
    calm_phase = 1'b1;
    queue_random(100, 60);
    drain();
    repeat (2 * MaxBlocks + 40) @(posedge clk_i);

    if (error_count == 0 && awaited_rsps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
